// File: sv/i2a_pkg.sv
// shared types, constants and helpers of the integer to ascii formatter
package i2a_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int VALUE_W     = 64;
  localparam int DIGIT_W     = 4;
  localparam int NUM_DIGITS  = 20;
  localparam int CNT_W       = $clog2(MAX_WIDTH + 1);
  localparam int DIG_IDX_W   = $clog2(NUM_DIGITS);
  localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);
  localparam int SHIFT_CNT_W = $clog2(VALUE_W);

  localparam logic [1:0] MODE_SDEC = 2'd0;
  localparam logic [1:0] MODE_UDEC = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  localparam logic [0:15][7:0] DIGIT_CHARS = "0123456789abcdef";

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef digit_t [NUM_DIGITS-1:0] digit_row_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] value;
    logic [6:0]  width;
    logic        pad_after;
  } in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } out_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic             pad_after;
    logic [CNT_W-1:0] width;
  } emit_req_t;

  function automatic logic [7:0] digit_char(input digit_t d);
    return DIGIT_CHARS[d];
  endfunction

endpackage

// File: sv/i2a_digit_cell.sv
// one digit cell of the shift-and-correct conversion chain
module i2a_digit_cell (
  input  logic            clk,
  input  logic            clear,
  input  logic            shift,
  input  logic            hex,
  input  logic            bit_in,
  output i2a_pkg::digit_t digit,
  output logic            carry
);
  import i2a_pkg::*;

  digit_t corr;

  always_comb begin
    if (!hex && digit >= DIGIT_W'(5)) begin
      corr = digit + DIGIT_W'(3);
    end else begin
      corr = digit;
    end
  end

  assign carry = corr[DIGIT_W-1];

  always_ff @(posedge clk) begin
    if (clear) begin
      digit <= '0;
    end else if (shift) begin
      digit <= {corr[DIGIT_W-2:0], bit_in};
    end
  end

endmodule

// File: sv/i2a_emitter.sv
// character sequencer and output register
module i2a_emitter (
  input  logic               clk,
  input  logic               rst,
  input  i2a_pkg::emit_req_t req,
  input  i2a_pkg::digit_row_t digits,
  output logic               done,
  output logic               out_valid,
  input  logic               out_ready,
  output i2a_pkg::out_t      out_data
);
  import i2a_pkg::*;

  typedef enum logic [2:0] {
    E_IDLE, E_SCAN, E_PREP, E_PADPRE, E_SIGN, E_DIGIT, E_PADPOST
  } estate_t;

  estate_t              state;
  logic                 neg;
  logic                 pad_after;
  logic [CNT_W-1:0]     width;
  logic [DIG_CNT_W-1:0] ndig;
  logic [DIG_IDX_W-1:0] dptr;
  logic [CNT_W-1:0]     pad_cnt;

  logic [DIG_CNT_W-1:0] ndig_scan;
  logic [CNT_W-1:0]     len;
  logic [CNT_W-1:0]     pad_calc;
  logic                 load;
  logic                 emit;

  // highest nonzero digit, zero still prints one digit
  always_comb begin
    ndig_scan = DIG_CNT_W'(1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digits[i] != '0) begin
        ndig_scan = DIG_CNT_W'(i + 1);
      end
    end
  end

  assign len      = CNT_W'(ndig) + CNT_W'(neg);
  assign pad_calc = (width > len) ? (width - len) : '0;
  assign load     = !out_valid || out_ready;
  assign emit     = load && ((state == E_PADPRE) || (state == E_SIGN) ||
                             (state == E_DIGIT) || (state == E_PADPOST));

  assign done = load && (((state == E_DIGIT) && (dptr == '0) && (pad_cnt == '0)) ||
                         ((state == E_PADPOST) && (pad_cnt == CNT_W'(1))));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && !out_ready);
      unique case (state)
        E_IDLE: begin
          if (req.start) begin
            neg       <= req.neg;
            pad_after <= req.pad_after;
            width     <= req.width;
            state     <= E_SCAN;
          end
        end
        E_SCAN: begin
          ndig  <= ndig_scan;
          dptr  <= DIG_IDX_W'(ndig_scan - DIG_CNT_W'(1));
          state <= E_PREP;
        end
        E_PREP: begin
          pad_cnt <= pad_calc;
          if (!pad_after && pad_calc != '0) begin
            state <= E_PADPRE;
          end else if (neg) begin
            state <= E_SIGN;
          end else begin
            state <= E_DIGIT;
          end
        end
        E_PADPRE: begin
          if (load) begin
            out_data.char_out <= CH_SPACE;
            out_data.last     <= 1'b0;
            pad_cnt           <= pad_cnt - CNT_W'(1);
            if (pad_cnt == CNT_W'(1)) begin
              state <= neg ? E_SIGN : E_DIGIT;
            end
          end
        end
        E_SIGN: begin
          if (load) begin
            out_data.char_out <= CH_MINUS;
            out_data.last     <= 1'b0;
            state             <= E_DIGIT;
          end
        end
        E_DIGIT: begin
          if (load) begin
            out_data.char_out <= digit_char(digits[dptr]);
            out_data.last     <= (dptr == '0) && (pad_cnt == '0);
            dptr              <= dptr - DIG_IDX_W'(1);
            if (dptr == '0) begin
              state <= (pad_cnt != '0) ? E_PADPOST : E_IDLE;
            end
          end
        end
        E_PADPOST: begin
          if (load) begin
            out_data.char_out <= CH_SPACE;
            out_data.last     <= (pad_cnt == CNT_W'(1));
            pad_cnt           <= pad_cnt - CNT_W'(1);
            if (pad_cnt == CNT_W'(1)) begin
              state <= E_IDLE;
            end
          end
        end
        default: begin
          state <= E_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/integer_to_ascii_formatter.sv
// integer to ascii formatter top level: input capture, conversion chain, emitter
//
// Input beats carry mode, value, width and pad_after on in_valid/in_ready.
// Output beats carry one ascii character each on out_valid/out_ready, with
// last set on the final character of a number's text.
// All 64 bits of the value are shifted msb first into a row of 20 four-bit
// digit cells; in decimal modes each cell adds three before a shift when it
// holds five or more, in hex mode cells just pass bits along.
// After the shift the emitter finds the digit count in its scan state and
// the padding in its prep state, then sends one character per cycle while
// the receiver does not stall.
// A beat with mode 3 is taken and gives no output.
// in_ready is high only while no conversion or text is in progress; the last
// character may still sit in the output register while the next number is
// converted. A receiver stall simply holds the current character.
// Reset returns both sequencers to idle and drops out_valid.
module integer_to_ascii_formatter (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  i2a_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output i2a_pkg::out_t out_data
);
  import i2a_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CONVERT, S_EMIT} state_t;

  state_t                 state;
  logic [VALUE_W-1:0]     sreg;
  logic [SHIFT_CNT_W-1:0] cnt;
  logic                   hex;
  logic                   neg;
  logic                   pad_after;
  logic [CNT_W-1:0]       width;

  logic                   accept;
  logic                   start_conv;
  logic [32:0]            mag_s;
  logic [CNT_W-1:0]       width_clamp;
  logic                   shift;
  logic                   done;
  emit_req_t              req;
  digit_row_t             digits;
  logic [NUM_DIGITS:0]    chain;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign start_conv = accept && ((in_data.mode == MODE_SDEC) ||
                                 (in_data.mode == MODE_UDEC) ||
                                 (in_data.mode == MODE_HEX));

  // magnitude of the low word, minimum value included
  assign mag_s = in_data.value[31] ?
                 (33'h1_0000_0000 - {1'b0, in_data.value[31:0]}) :
                 {1'b0, in_data.value[31:0]};

  assign width_clamp = (32'(in_data.width) > 32'(MAX_WIDTH)) ?
                       CNT_W'(MAX_WIDTH) : CNT_W'(in_data.width);

  assign shift = (state == S_CONVERT);

  assign req.start     = (state == S_CONVERT) && (cnt == SHIFT_CNT_W'(VALUE_W - 1));
  assign req.neg       = neg;
  assign req.pad_after = pad_after;
  assign req.width     = width;

  assign chain[0] = sreg[VALUE_W-1];

  for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
    i2a_digit_cell u_cell (
      .clk    (clk),
      .clear  (start_conv),
      .shift  (shift),
      .hex    (hex),
      .bit_in (chain[g]),
      .digit  (digits[g]),
      .carry  (chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cnt       <= '0;
            pad_after <= in_data.pad_after;
            width     <= width_clamp;
            unique case (in_data.mode)
              MODE_SDEC: begin
                sreg  <= VALUE_W'(mag_s);
                neg   <= in_data.value[31];
                hex   <= 1'b0;
                state <= S_CONVERT;
              end
              MODE_UDEC: begin
                sreg  <= in_data.value;
                neg   <= 1'b0;
                hex   <= 1'b0;
                state <= S_CONVERT;
              end
              MODE_HEX: begin
                sreg  <= in_data.value;
                neg   <= 1'b0;
                hex   <= 1'b1;
                state <= S_CONVERT;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_CONVERT: begin
          sreg <= {sreg[VALUE_W-2:0], 1'b0};
          cnt  <= cnt + SHIFT_CNT_W'(1);
          if (cnt == SHIFT_CNT_W'(VALUE_W - 1)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  i2a_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .digits    (digits),
    .done      (done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
